FILE: rtl/nrom_pkg.sv
// Shared types, constants and codes for the nullable row offset map.
package nrom_pkg;

	// store geometry
	localparam int SLOT_DEPTH = 65536;
	localparam int ADDR_W     = $clog2(SLOT_DEPTH);
	localparam int CNT_W      = ADDR_W + 1;

	// fixed field widths
	localparam int OFF_W      = 32;
	localparam int ROW_W      = 31;
	localparam int VROWS_W    = 17;
	localparam int FUNC_W     = 3;
	localparam int STAT_W     = 2;
	localparam int IN_DATA_W  = 32;
	localparam int IN_USER_W  = 4;
	localparam int OUT_DATA_W = 88;

	localparam logic [ROW_W-1:0] ROW_MAX = {ROW_W{1'b1}};

	// request function codes
	localparam logic [FUNC_W-1:0] FUNC_APPEND = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_L2P    = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_P2L    = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_COUNT  = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_FILTER = 3'd4;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
	localparam logic [STAT_W-1:0] STAT_OVF  = 2'd2;

	// classified command
	typedef enum logic [2:0] {
		CMD_NOP,
		CMD_APPEND_VALID,
		CMD_APPEND_NULL,
		CMD_L2P,
		CMD_P2L,
		CMD_COUNT,
		CMD_FILTER
	} cmd_t;

	// one queued request
	typedef struct packed {
		cmd_t             cmd;
		logic [OFF_W-1:0] offset;
		logic             last;
	} item_t;

	// back-end sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_CMP,
		ST_P2L
	} state_t;

endpackage

FILE: rtl/nrom_front.sv
// Front end: accepts requests and classifies them into commands.
module nrom_front
	import nrom_pkg::*;
(
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,
	input  logic [IN_USER_W-1:0] s_tuser,
	input  logic                 s_tlast,
	input  logic                 q_full,
	output logic                 push,
	output item_t                push_item
);

	logic [FUNC_W-1:0] func;
	logic              row_valid;

	assign func      = s_tuser[FUNC_W-1:0];
	assign row_valid = s_tuser[FUNC_W];

	// accept while the queue has room
	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	// classify the request
	always_comb begin
		push_item.offset = s_tdata[OFF_W-1:0];
		push_item.last   = s_tlast;
		case (func)
			FUNC_APPEND: push_item.cmd = row_valid ? CMD_APPEND_VALID : CMD_APPEND_NULL;
			FUNC_L2P:    push_item.cmd = CMD_L2P;
			FUNC_P2L:    push_item.cmd = CMD_P2L;
			FUNC_COUNT:  push_item.cmd = CMD_COUNT;
			FUNC_FILTER: push_item.cmd = CMD_FILTER;
			default:     push_item.cmd = CMD_NOP;
		endcase
	end

endmodule

FILE: rtl/nrom_queue.sv
// Two-entry command queue between the front and back ends.
module nrom_queue
	import nrom_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output item_t head_item
);

	item_t      entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full       = cnt_q == 2'd2;
	assign head_valid = cnt_q != 2'd0;
	assign head_item  = entry_q[rd_ptr_q];

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	// hold entries
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_item;
	end

endmodule

FILE: rtl/nrom_back.sv
// Back end: slot store, row counters, binary search sequencer and result register.
module nrom_back
	import nrom_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  item_t                 q_item,
	output logic                  q_pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tlast
);

	// slot store
	logic [ROW_W-1:0] mem [SLOT_DEPTH];
	logic [ROW_W-1:0] rdata_q;

	// counters and sequencer
	state_t           state_q, state_d;
	logic [CNT_W-1:0] valid_q;
	logic [ROW_W-1:0] total_q;

	// per-request context
	cmd_t             cmd_q;
	logic [OFF_W-1:0] off_q;
	logic             last_q;
	logic [CNT_W-1:0] lo_q;
	logic [CNT_W-1:0] hi_q;
	logic             eq_q;

	// result register
	logic              out_valid_q;
	logic [OFF_W-1:0]  res_q;
	logic              found_q;
	logic [STAT_W-1:0] stat_q;
	logic [CNT_W-1:0]  vrows_q;
	logic [ROW_W-1:0]  trows_q;
	logic              blast_q;

	// control
	logic              go;
	logic              go_search;
	logic              go_p2l;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic              we;
	logic              fin;
	logic [OFF_W-1:0]  fin_res;
	logic              fin_found;
	logic [STAT_W-1:0] fin_stat;
	logic              fin_last;
	logic [CNT_W-1:0]  new_valid;
	logic [ROW_W-1:0]  total_nx;

	// operand tests on the queue head
	logic [OFF_W-1:0]  off;
	logic              t_zero;
	logic              off_neg;
	logic              off_ge_t;
	logic              off_lt_v;
	logic              off_le0;
	logic              v_eq_t;
	logic              app_ovf;
	logic              app_full;
	logic [CNT_W-1:0]  mid;
	logic              rd_lt;

	assign off      = q_item.offset;
	assign t_zero   = total_q == '0;
	assign off_neg  = off[OFF_W-1];
	assign off_ge_t = $signed(off) >= $signed({1'b0, total_q});
	assign off_lt_v = !off_neg && (off < OFF_W'(valid_q));
	assign off_le0  = off_neg || (off == '0);
	assign v_eq_t   = ROW_W'(valid_q) == total_q;
	assign app_ovf  = total_q == ROW_MAX;
	assign app_full = valid_q == CNT_W'(SLOT_DEPTH);
	assign go       = q_valid && (!out_valid_q || m_tready);
	assign mid      = lo_q + ((hi_q - lo_q) >> 1);
	assign rd_lt    = rdata_q < off_q[ROW_W-1:0];

	// decode actions for the current state
	always_comb begin
		q_pop     = 1'b0;
		go_search = 1'b0;
		go_p2l    = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = mid[ADDR_W-1:0];
		we        = 1'b0;
		fin       = 1'b0;
		fin_res   = '1;
		fin_found = 1'b0;
		fin_stat  = STAT_OK;
		fin_last  = last_q;
		new_valid = valid_q;
		total_nx  = total_q;
		case (state_q)
			ST_IDLE: begin
				if (go) begin
					q_pop    = 1'b1;
					fin      = 1'b1;
					fin_last = q_item.last;
					case (q_item.cmd)
						CMD_APPEND_VALID, CMD_APPEND_NULL: begin
							if (app_ovf) begin
								fin_stat = STAT_OVF;
							end else if (q_item.cmd == CMD_APPEND_VALID && app_full) begin
								fin_stat = STAT_FULL;
							end else begin
								total_nx = total_q + 1'b1;
								if (q_item.cmd == CMD_APPEND_VALID) begin
									we        = 1'b1;
									fin_res   = OFF_W'(valid_q);
									fin_found = 1'b1;
									new_valid = valid_q + 1'b1;
								end
							end
						end
						CMD_L2P, CMD_FILTER: begin
							if (t_zero) begin
								fin_res   = (q_item.cmd == CMD_FILTER && off_neg) ? '1 : off;
								fin_found = !off_neg;
							end else if (off_neg || off_ge_t) begin
								fin_res = '1;
							end else if (v_eq_t) begin
								fin_res   = off;
								fin_found = 1'b1;
							end else begin
								fin       = 1'b0;
								go_search = 1'b1;
							end
						end
						CMD_P2L: begin
							if (t_zero) begin
								fin_res   = off;
								fin_found = !off_neg;
							end else if (off_lt_v) begin
								fin     = 1'b0;
								go_p2l  = 1'b1;
								rd_en   = 1'b1;
								rd_addr = off[ADDR_W-1:0];
							end else begin
								fin_res = '1;
							end
						end
						CMD_COUNT: begin
							if (t_zero)
								fin_res = off_neg ? '0 : off;
							else if (off_le0)
								fin_res = '0;
							else if (off_ge_t)
								fin_res = OFF_W'(valid_q);
							else begin
								fin       = 1'b0;
								go_search = 1'b1;
							end
						end
						default: begin
							fin_res = '1;
						end
					endcase
				end
			end
			ST_SEARCH: begin
				if (lo_q < hi_q) begin
					rd_en = 1'b1;
				end else begin
					fin = 1'b1;
					if (cmd_q == CMD_COUNT) begin
						fin_res = OFF_W'(lo_q);
					end else begin
						fin_res   = eq_q ? OFF_W'(lo_q) : '1;
						fin_found = eq_q;
					end
				end
			end
			ST_P2L: begin
				fin       = 1'b1;
				fin_res   = OFF_W'(rdata_q);
				fin_found = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (go_search)
					state_d = ST_SEARCH;
				else if (go_p2l)
					state_d = ST_P2L;
			end
			ST_SEARCH: state_d = (lo_q < hi_q) ? ST_CMP : ST_IDLE;
			ST_CMP:    state_d = ST_SEARCH;
			ST_P2L:    state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// control registers and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= new_valid;
			total_q <= total_nx;
			if (fin)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	// capture request context and narrow the search window
	always_ff @(posedge clk) begin
		if (go_search || go_p2l) begin
			cmd_q  <= q_item.cmd;
			off_q  <= q_item.offset;
			last_q <= q_item.last;
			lo_q   <= '0;
			hi_q   <= valid_q;
			eq_q   <= 1'b0;
		end else if (state_q == ST_CMP) begin
			if (rd_lt) begin
				lo_q <= mid + 1'b1;
			end else begin
				hi_q <= mid;
				eq_q <= rdata_q == off_q[ROW_W-1:0];
			end
		end
	end

	// load result register
	always_ff @(posedge clk) begin
		if (fin) begin
			res_q   <= fin_res;
			found_q <= fin_found;
			stat_q  <= fin_stat;
			vrows_q <= new_valid;
			trows_q <= total_nx;
			blast_q <= fin_last;
		end
	end

	// slot store write and registered read
	always_ff @(posedge clk) begin
		if (we)
			mem[valid_q[ADDR_W-1:0]] <= total_q;
		if (rd_en)
			rdata_q <= mem[rd_addr];
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = blast_q;
	assign m_tdata  = {5'b0, trows_q, VROWS_W'(vrows_q), stat_q, found_q, res_q};

endmodule

FILE: rtl/nullable_row_offset_map_unit.sv
// Top level: nullable row offset map with decoupled front end, queue and back end.
// Appends, unused codes and queries settled by the counters go from the queue straight to
// the result register; physical to logical lookups first read the store; searches make one
// store read and compare a step; a lookup or search holds off the next request till done.
// Throughput: one request per cycle without a store read, while the output is not stalled.
// Reset clears the row counters, the queue and the result valid flag, not the slot store.
module nullable_row_offset_map_unit
	import nrom_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [31:0] offset
	input  logic [IN_USER_W-1:0]  s_tuser,   // [2:0] func, [3] row_valid
	input  logic                  s_tlast,   // batch_last
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [31:0] result_value, [32] found,
	                                         // [34:33] status, [51:35] valid_rows,
	                                         // [82:52] total_rows, [87:83] zero
	output logic                  m_tlast    // batch_end
);

	logic  push;
	item_t push_item;
	logic  q_full;
	logic  q_pop;
	logic  head_valid;
	item_t head_item;

	nrom_front u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	nrom_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	nrom_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (head_valid),
		.q_item   (head_item),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
